@@ hdl/ppfl_pkg.sv @@
// Shared constants, codes and helper functions of the per-CPU page free-list allocator.
`default_nettype none

package ppfl_pkg;

  // Sizing of the allocator.
  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  // Fixed field widths of the channels and the register.
  localparam int MODE_W = 1;
  localparam int REQ_W  = 3;
  localparam int ADDR_W = 27;
  localparam int STAT_W = 2;
  localparam int SRC_W  = 3;
  localparam int LOWB_W = 28;
  localparam int LINK_W = 16;

  // Derived widths and limits.
  localparam int CPU_W      = $clog2(NUM_CPUS);
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam longint MEM_TOP = longint'(NUM_PAGES) * longint'(PAGE_BYTES);

  localparam logic [LINK_W-1:0] NULL_LINK = '1;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  // Configuration port.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_LOW_BOUND = CFG_AW'(0);

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_ALLOC    = 2'd0,
    STAT_FREED    = 2'd1,
    STAT_NONE     = 2'd2,
    STAT_BAD_ADDR = 2'd3
  } status_t;

  // Reduces a requester number modulo the CPU count by repeated subtraction.
  function automatic logic [CPU_W-1:0] cpu_of(input logic [REQ_W-1:0] v);
    logic [REQ_W:0] r;
    r = {1'b0, v};
    for (int k = 0; k < (1 << REQ_W); k++) begin
      if (32'(r) >= NUM_CPUS) begin
        r = r - (REQ_W + 1)'(NUM_CPUS);
      end
    end
    return CPU_W'(r);
  endfunction

  // Next CPU in round-robin order.
  function automatic logic [CPU_W-1:0] cpu_next(input logic [CPU_W-1:0] c);
    if (32'(c) == NUM_CPUS - 1) begin
      return '0;
    end
    return c + CPU_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ hdl/ppfl_if.sv @@
// Valid/ready channel interfaces for requests and results of the page allocator.
`default_nettype none

interface ppfl_in_if
  import ppfl_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  requester_cpu;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, mode, requester_cpu, free_address, input ready);
  modport sink   (input valid, mode, requester_cpu, free_address, output ready);
endinterface

interface ppfl_out_if
  import ppfl_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] page_address;
  logic [SRC_W-1:0]  source_cpu;

  modport source (output valid, status, page_address, source_cpu, input ready);
  modport sink   (input valid, status, page_address, source_cpu, output ready);
endinterface

`default_nettype wire

@@ hdl/ppfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/per_cpu_page_free_list_allocator.sv @@
// Top level of the per-CPU LIFO page free-list allocator with work stealing.
//
//  channel  | dir | handshake       | word contents
//  ---------+-----+-----------------+------------------------------------------
//  in_ch    | in  | valid/ready     | mode, requester_cpu, free_address
//  out_ch   | out | valid/ready     | status, page_address, source_cpu
//  cfg_*    | in  | APB write/read  | low_bound at byte address 0
//
// A free passes from acceptance through the decode state, which checks the
// address and pushes, and the emit state, which loads the result register.
// An allocate that finds a page passes through decode, scan, pop and emit,
// where the scan skips s (0 .. NUM_CPUS-1) empty lists first; the next-link
// memory read of the pop is issued from the scan. An allocate that finds
// nothing tries all NUM_CPUS lists. The input side is ready only while the
// sequencer is idle, which it is from the cycle after the result loads.
// Reset (rst_n low, synchronous) empties every list at once; the link memory
// needs no clearing since a link is always written before it is read.
// While the output register holds a word that is not taken, the next result
// waits in the emit state and the input side stays closed.
`default_nettype none

module per_cpu_page_free_list_allocator
  import ppfl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  ppfl_in_if.sink             in_ch,
  ppfl_out_if.source          out_ch,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire  [CFG_AW-1:0]   cfg_paddr,
  input  wire  [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_POP    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;

  // Latched request.
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] addr_r;
  // CPU list under work, and how many lists the scan has already tried.
  logic [CPU_W-1:0]  cpu_r;
  logic [CPU_W-1:0]  step_r;
  // Page popped from the current list head, waiting for its link.
  logic [LINK_W-1:0] pg_r;

  // Pending result, then the output register.
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_page_r;
  logic [SRC_W-1:0]  res_src_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_page_r;
  logic [SRC_W-1:0]  out_src_r;

  logic [LOWB_W-1:0] low_bound_r;
  logic [LINK_W-1:0] heads_r [NUM_CPUS];

  logic              in_fire;
  logic              out_fire;
  logic              out_free;
  logic              out_load;
  logic              cfg_wr;
  logic [LINK_W-1:0] head_q;
  logic              head_empty;
  logic              free_ok;
  logic [LINK_W-1:0] page_idx;
  logic              last_step;

  logic              ram_we;
  logic              ram_re;
  logic [LINK_W-1:0] ram_rdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_EMIT) && out_free;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                    (cfg_paddr == REG_LOW_BOUND);

  // Only one list head is looked at in any cycle: the one of cpu_r.
  assign head_q     = heads_r[cpu_r];
  assign head_empty = (32'(head_q) >= NUM_PAGES);
  assign last_step  = (32'(step_r) == NUM_CPUS - 1);

  // A freed address must be page aligned, at or above the low bound and
  // inside the memory.
  assign free_ok  = ((addr_r & PAGE_MASK) == '0) &&
                    ({1'b0, addr_r} >= low_bound_r) &&
                    (64'(addr_r) < 64'(MEM_TOP));
  assign page_idx = LINK_W'(addr_r >> PAGE_SHIFT);

  // A push writes the old head as the new page's link; a pop reads the link
  // of the head page so that it becomes the new head.
  assign ram_we = (state_r == ST_DECODE) && (mode_r == MODE_FREE) && free_ok;
  assign ram_re = (state_r == ST_SCAN) && !head_empty;

  ppfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (page_idx[PAGE_W-1:0]),
    .wdata (head_q),
    .re    (ram_re),
    .raddr (head_q[PAGE_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = (mode_r == MODE_FREE) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (!head_empty) begin
          state_nxt = ST_POP;
        end else if (last_step) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_POP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      low_bound_r <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        heads_r[i] <= NULL_LINK;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        low_bound_r <= LOWB_W'(cfg_pwdata);
      end

      // A new result may replace the one being taken in the same cycle.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            mode_r <= in_ch.mode;
            addr_r <= in_ch.free_address;
            cpu_r  <= cpu_of(in_ch.requester_cpu);
            step_r <= '0;
          end
        end
        ST_DECODE: begin
          res_page_r <= '0;
          res_src_r  <= '0;
          if (mode_r == MODE_FREE) begin
            if (free_ok) begin
              heads_r[cpu_r] <= page_idx;
              res_status_r   <= STAT_FREED;
            end else begin
              res_status_r   <= STAT_BAD_ADDR;
            end
          end
        end
        ST_SCAN: begin
          // Walk the lists in round-robin order from the requester's own.
          if (!head_empty) begin
            pg_r <= head_q;
          end else if (last_step) begin
            res_status_r <= STAT_NONE;
          end else begin
            cpu_r  <= cpu_next(cpu_r);
            step_r <= step_r + CPU_W'(1);
          end
        end
        ST_POP: begin
          heads_r[cpu_r] <= ram_rdata;
          res_status_r   <= STAT_ALLOC;
          res_page_r     <= ADDR_W'(32'(pg_r) << PAGE_SHIFT);
          res_src_r      <= SRC_W'(cpu_r);
        end
        ST_EMIT: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_page_r   <= res_page_r;
            out_src_r    <= res_src_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.page_address = out_page_r;
  assign out_ch.source_cpu   = out_src_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_LOW_BOUND) ? CFG_DW'(low_bound_r) : '0;

endmodule

`default_nettype wire

@@ hdl/ppfl_checker.sv @@
// Port-level checks of the page allocator, bound to its top level.
`default_nettype none

module ppfl_checker
  import ppfl_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [STAT_W-1:0] status,
  input wire [ADDR_W-1:0] page_address,
  input wire [SRC_W-1:0]  source_cpu
);

  // Words accepted whose results are not yet delivered.
  logic [1:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result shown without an outstanding request");

  a_zero_unless_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_ALLOC |-> page_address == '0 && source_cpu == '0)
    else $error("page fields nonzero on a non-allocate result");

  a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_ALLOC |-> (page_address & PAGE_MASK) == '0)
    else $error("allocated page is not page aligned");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(page_address) && $stable(source_cpu))
    else $error("stalled result changed or dropped");

endmodule

bind per_cpu_page_free_list_allocator ppfl_checker u_ppfl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .page_address (out_ch.page_address),
  .source_cpu   (out_ch.source_cpu)
);

`default_nettype wire
